// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// Depends on nothing; used by i2cm_step and i2c_master_bit_engine.
package i2cm_pkg;

	// Phase codes of the bit sequencer
	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_STA_A  = 5'd1,
		PH_STA_B  = 5'd2,
		PH_STO_A  = 5'd3,
		PH_STO_B  = 5'd4,
		PH_W_LOW  = 5'd5,
		PH_W_HIGH = 5'd6,
		PH_W_TAIL = 5'd7,
		PH_A_REL  = 5'd8,
		PH_A_POLL = 5'd9,
		PH_R_LOW  = 5'd10,
		PH_R_HIGH = 5'd11,
		PH_K_LOW  = 5'd12,
		PH_K_HIGH = 5'd13
	} phase_t;

	localparam logic       ACT_TICK = 1'b0;
	localparam logic       ACT_CMD  = 1'b1;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic       REG_ACK_TIMEOUT     = 1'b0;
	localparam logic       REG_TICKS_PER_PHASE = 1'b1;

	// Line register bits: bit 0 SCL, bit 1 SDA, bit 2 SDA output enable
	localparam logic [2:0] L_SCL = 3'b001;
	localparam logic [2:0] L_SDA = 3'b010;
	localparam logic [2:0] L_OE  = 3'b100;

	localparam logic [7:0] ACK_TIMEOUT_RST     = 8'd50;
	localparam logic [7:0] TICKS_PER_PHASE_RST = 8'd1;
	localparam logic [2:0] LAST_BIT            = 3'd7;

	typedef struct packed {
		logic       action;
		logic [1:0] command;
		logic [7:0] tx_byte;
		logic       ack_after_read;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        sda_is_output;
		logic        busy_res;
		logic        done_res;
		logic [7:0]  rx_byte;
		logic        nack_error;
		logic [15:0] error_count;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bit_index;
		logic [7:0]  shift_reg;
		logic [8:0]  ticks_left;
		logic [7:0]  ack_wait;
		logic [2:0]  lines;
		logic        ack_choice;
		logic [15:0] timeout_total;
		logic        nack_flag;
		logic [7:0]  last_rx;
	} engine_state_t;

endpackage

// ===== src/i2cm_step.sv =====
// Next-state and result logic of the I2C master bit engine for one word.
// Depends on i2cm_pkg.
module i2cm_step (
	input  i2cm_pkg::engine_state_t st,
	input  i2cm_pkg::item_t         item,
	input  logic [7:0]              ack_timeout,
	input  logic [7:0]              ticks_per_phase,
	output i2cm_pkg::engine_state_t nxt,
	output i2cm_pkg::result_t       res
);

	logic [7:0] unit;
	logic [8:0] one_unit;
	logic [8:0] two_units;
	logic [7:0] rx_shift;
	logic       done;

	assign unit      = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
	assign one_unit  = {1'b0, unit};
	assign two_units = {unit, 1'b0};
	assign rx_shift  = {st.shift_reg[6:0], item.sda_sample};

	always_comb begin
		nxt  = st;
		done = 1'b0;
		if (item.action == i2cm_pkg::ACT_CMD) begin
			if (st.phase == i2cm_pkg::PH_IDLE) begin
				nxt.bit_index = 3'd0;
				case (item.command)
					i2cm_pkg::CMD_START: begin
						nxt.phase      = i2cm_pkg::PH_STA_A;
						nxt.ticks_left = two_units;
						nxt.lines      = i2cm_pkg::L_OE | i2cm_pkg::L_SCL | i2cm_pkg::L_SDA;
					end
					i2cm_pkg::CMD_STOP: begin
						nxt.phase      = i2cm_pkg::PH_STO_A;
						nxt.ticks_left = two_units;
						nxt.lines      = i2cm_pkg::L_OE;
					end
					i2cm_pkg::CMD_WRITE: begin
						nxt.shift_reg  = item.tx_byte;
						nxt.phase      = i2cm_pkg::PH_W_LOW;
						nxt.ticks_left = one_unit;
						nxt.lines      = i2cm_pkg::L_OE | (item.tx_byte[7] ? i2cm_pkg::L_SDA : 3'b000);
					end
					default: begin
						nxt.shift_reg  = 8'd0;
						nxt.ack_choice = item.ack_after_read;
						nxt.phase      = i2cm_pkg::PH_R_LOW;
						nxt.ticks_left = one_unit;
						nxt.lines      = i2cm_pkg::L_SDA;
					end
				endcase
			end
		end else if (st.phase == i2cm_pkg::PH_IDLE) begin
			nxt = st;
		end else if (st.phase == i2cm_pkg::PH_A_POLL) begin
			if (!item.sda_sample) begin
				nxt.nack_flag = 1'b0;
				nxt.lines     = st.lines & ~i2cm_pkg::L_SCL;
				nxt.phase     = i2cm_pkg::PH_IDLE;
				done          = 1'b1;
			end else if ({1'b0, st.ack_wait} + 9'd1 > {1'b0, ack_timeout}) begin
				nxt.nack_flag     = 1'b1;
				nxt.timeout_total = st.timeout_total + 16'd1;
				nxt.phase         = i2cm_pkg::PH_STO_A;
				nxt.ticks_left    = two_units;
				nxt.lines         = i2cm_pkg::L_OE;
			end else begin
				nxt.ack_wait = st.ack_wait + 8'd1;
			end
		end else if (st.ticks_left > 9'd1) begin
			nxt.ticks_left = st.ticks_left - 9'd1;
		end else begin
			case (st.phase)
				i2cm_pkg::PH_STA_A: begin
					nxt.phase      = i2cm_pkg::PH_STA_B;
					nxt.ticks_left = two_units;
					nxt.lines      = i2cm_pkg::L_OE | i2cm_pkg::L_SCL;
				end
				i2cm_pkg::PH_STA_B: begin
					nxt.lines = i2cm_pkg::L_OE;
					nxt.phase = i2cm_pkg::PH_IDLE;
					done      = 1'b1;
				end
				i2cm_pkg::PH_STO_A: begin
					nxt.phase      = i2cm_pkg::PH_STO_B;
					nxt.ticks_left = two_units;
					nxt.lines      = i2cm_pkg::L_OE | i2cm_pkg::L_SCL | i2cm_pkg::L_SDA;
				end
				i2cm_pkg::PH_STO_B: begin
					nxt.phase = i2cm_pkg::PH_IDLE;
					done      = 1'b1;
				end
				i2cm_pkg::PH_W_LOW: begin
					nxt.phase      = i2cm_pkg::PH_W_HIGH;
					nxt.ticks_left = one_unit;
					nxt.lines      = st.lines | i2cm_pkg::L_SCL;
				end
				i2cm_pkg::PH_W_HIGH: begin
					nxt.phase      = i2cm_pkg::PH_W_TAIL;
					nxt.ticks_left = one_unit;
					nxt.lines      = st.lines & ~i2cm_pkg::L_SCL;
				end
				i2cm_pkg::PH_W_TAIL: begin
					nxt.ticks_left = one_unit;
					if (st.bit_index < i2cm_pkg::LAST_BIT) begin
						nxt.bit_index = st.bit_index + 3'd1;
						nxt.shift_reg = {st.shift_reg[6:0], 1'b0};
						nxt.phase     = i2cm_pkg::PH_W_LOW;
						nxt.lines     = i2cm_pkg::L_OE |
							(st.shift_reg[6] ? i2cm_pkg::L_SDA : 3'b000);
					end else begin
						nxt.phase = i2cm_pkg::PH_A_REL;
						nxt.lines = i2cm_pkg::L_SDA;
					end
				end
				i2cm_pkg::PH_A_REL: begin
					nxt.phase      = i2cm_pkg::PH_A_POLL;
					nxt.ticks_left = one_unit;
					nxt.lines      = i2cm_pkg::L_SDA | i2cm_pkg::L_SCL;
					nxt.ack_wait   = 8'd0;
				end
				i2cm_pkg::PH_R_LOW: begin
					nxt.phase      = i2cm_pkg::PH_R_HIGH;
					nxt.ticks_left = one_unit;
					nxt.lines      = i2cm_pkg::L_SDA | i2cm_pkg::L_SCL;
				end
				i2cm_pkg::PH_R_HIGH: begin
					// take the bit on the last tick of the SCL-high unit
					nxt.shift_reg  = rx_shift;
					nxt.ticks_left = one_unit;
					if (st.bit_index < i2cm_pkg::LAST_BIT) begin
						nxt.bit_index = st.bit_index + 3'd1;
						nxt.phase     = i2cm_pkg::PH_R_LOW;
						nxt.lines     = i2cm_pkg::L_SDA;
					end else begin
						nxt.last_rx = rx_shift;
						nxt.phase   = i2cm_pkg::PH_K_LOW;
						nxt.lines   = i2cm_pkg::L_OE |
							(st.ack_choice ? 3'b000 : i2cm_pkg::L_SDA);
					end
				end
				i2cm_pkg::PH_K_LOW: begin
					nxt.phase      = i2cm_pkg::PH_K_HIGH;
					nxt.ticks_left = one_unit;
					nxt.lines      = st.lines | i2cm_pkg::L_SCL;
				end
				i2cm_pkg::PH_K_HIGH: begin
					nxt.lines = st.lines & ~i2cm_pkg::L_SCL;
					nxt.phase = i2cm_pkg::PH_IDLE;
					done      = 1'b1;
				end
				default: begin
					nxt.phase = i2cm_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.scl_level     = nxt.lines[0];
		res.sda_level     = nxt.lines[1];
		res.sda_is_output = nxt.lines[2];
		res.busy_res      = (nxt.phase != i2cm_pkg::PH_IDLE);
		res.done_res      = done;
		res.rx_byte       = nxt.last_rx;
		res.nack_error    = nxt.nack_flag;
		res.error_count   = nxt.timeout_total;
	end

endmodule

// ===== src/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: input register, phase state and
// result register. Depends on i2cm_pkg and i2cm_step.
//
// Each input word is either a command (start, stop, write byte, read byte) or
// a time tick carrying the sampled SDA level, and each word yields exactly one
// result word with the driven SCL/SDA levels, the SDA direction, busy/done
// flags, the last received byte, the NACK flag and a wrapping count of ACK
// timeouts. Words are taken at one per clock cycle while the result side does not
// stall: an accepted word is held in the input register, the phase state is updated
// from it by combinational logic, and its result is registered in the output
// register. The rate is set by that single phase-state update, which handles one
// word per cycle. A stalled result register holds the input register, which then
// raises stall. Configuration (index 0 ACK timeout, index 1 ticks per phase) is
// always ready and must only be written while the engine is idle with no word in
// flight.
module i2c_master_bit_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  i2cm_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output i2cm_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	i2cm_pkg::item_t         item_s1;
	logic                    valid_s1;
	i2cm_pkg::engine_state_t st_q;
	i2cm_pkg::engine_state_t st_nxt;
	i2cm_pkg::result_t       res_nxt;
	logic [7:0]              ack_timeout_q;
	logic [7:0]              ticks_per_phase_q;
	logic                    advance;
	logic                    accept;

	// Advance the held word when the result register is empty or being drained
	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q     <= i2cm_pkg::ACK_TIMEOUT_RST;
			ticks_per_phase_q <= i2cm_pkg::TICKS_PER_PHASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2cm_pkg::REG_ACK_TIMEOUT:     ack_timeout_q     <= cfg_data;
				i2cm_pkg::REG_TICKS_PER_PHASE: ticks_per_phase_q <= cfg_data;
				default:                       ack_timeout_q     <= ack_timeout_q;
			endcase
		end
	end

	i2cm_step u_step (
		.st              (st_q),
		.item            (item_s1),
		.ack_timeout     (ack_timeout_q),
		.ticks_per_phase (ticks_per_phase_q),
		.nxt             (st_nxt),
		.res             (res_nxt)
	);

	// Phase state: lines idle high and driven after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= i2cm_pkg::PH_IDLE;
			st_q.bit_index     <= 3'd0;
			st_q.shift_reg     <= 8'd0;
			st_q.ticks_left    <= 9'd0;
			st_q.ack_wait      <= 8'd0;
			st_q.lines         <= i2cm_pkg::L_OE | i2cm_pkg::L_SCL | i2cm_pkg::L_SDA;
			st_q.ack_choice    <= 1'b0;
			st_q.timeout_total <= 16'd0;
			st_q.nack_flag     <= 1'b0;
			st_q.last_rx       <= 8'd0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= res_nxt;
		end
	end

	// A completed command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done reported while busy");

	// A stalled result freezes the phase state
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(st_q))
		else $error("phase state moved under a stalled result");

	// The timeout count only moves together with a raised NACK flag
	a_err_nack: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (st_nxt.timeout_total != st_q.timeout_total) |-> st_nxt.nack_flag)
		else $error("timeout counted without NACK");

	// Stall is raised only while a word is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid)
		else $error("stall without a held word");

endmodule

// ===== sim/i2c_master_bit_engine_test.sv =====
// Self-checking testbench for the I2C master bit engine: random bus transactions,
// bursty input words, patterned output stalls and a word-by-word engine predictor.
// Depends on i2cm_pkg and the i2c_master_bit_engine RTL.
module i2c_master_bit_engine_test;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	i2cm_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	i2cm_pkg::result_t result;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic              cfg_index    = i2cm_pkg::REG_ACK_TIMEOUT;
	logic        [7:0] cfg_data     = 8'd0;

	i2c_master_bit_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Words waiting to be driven, and the result words the engine owes us
	i2cm_pkg::item_t   pending_words[$];
	i2cm_pkg::result_t expected_results[$];

	int      fail_count        = 0;
	int      planned_words     = 0;
	bit      word_taken        = 1'b0;
	bit      wide_timeout_done = 1'b0;

	// Shadow copy of the engine: sequencer state and the two registers
	i2cm_pkg::phase_t  ph         = i2cm_pkg::PH_IDLE;
	logic  [3:0]       bit_idx    = 4'd0;
	logic  [7:0]       shreg      = 8'd0;
	logic  [8:0]       ticks_left = 9'd0;
	logic  [7:0]       ack_wait   = 8'd0;
	logic  [2:0]       lines      = i2cm_pkg::L_OE | i2cm_pkg::L_SCL | i2cm_pkg::L_SDA;
	logic              ack_sel    = 1'b0;
	logic  [15:0]      timeouts   = 16'd0;
	logic              nack       = 1'b0;
	logic  [7:0]       rx_last    = 8'd0;
	logic  [7:0]       ack_limit  = i2cm_pkg::ACK_TIMEOUT_RST;
	logic  [7:0]       phase_unit = i2cm_pkg::TICKS_PER_PHASE_RST;
	i2cm_pkg::result_t forecast;

	// Sender burst shaping and receiver stall pattern
	int burst_left = 0;
	int gap_left   = 0;
	int stall_mode = 0;
	int stall_hold = 0;
	int stall_beat = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Engine predictor
	// ------------------------------------------------------------------

	// Move to a phase: set its line levels now, its length counts from the next tick.
	// A ticks-per-phase value of zero behaves as one.
	function automatic void enter_phase(input i2cm_pkg::phase_t target, input int units,
			input logic [2:0] lvl);
		ph         = target;
		ticks_left = 9'(units * ((phase_unit == 8'd0) ? 1 : int'(phase_unit)));
		lines      = lvl;
	endfunction

	// Advance the sequencer by one tick; returns 1 when the command finishes on it.
	function automatic logic advance_tick(input logic sda);
		logic fin;
		fin = 1'b0;
		if (ph == i2cm_pkg::PH_A_POLL) begin
			// Poll once per tick: low is an ACK, too many highs is a timeout
			if (!sda) begin
				nack  = 1'b0;
				lines = lines & ~i2cm_pkg::L_SCL;
				ph    = i2cm_pkg::PH_IDLE;
				fin   = 1'b1;
			end else if (int'(ack_wait) + 1 > int'(ack_limit)) begin
				nack     = 1'b1;
				timeouts = timeouts + 16'd1;
				enter_phase(i2cm_pkg::PH_STO_A, 2, i2cm_pkg::L_OE);
			end else
				ack_wait = ack_wait + 8'd1;
		end else if (ph != i2cm_pkg::PH_IDLE) begin
			if (ticks_left > 9'd1)
				ticks_left = ticks_left - 9'd1;
			else begin
				case (ph)
					i2cm_pkg::PH_STA_A:
						enter_phase(i2cm_pkg::PH_STA_B, 2, i2cm_pkg::L_OE | i2cm_pkg::L_SCL);
					i2cm_pkg::PH_STA_B: begin
						lines = i2cm_pkg::L_OE;
						ph    = i2cm_pkg::PH_IDLE;
						fin   = 1'b1;
					end
					i2cm_pkg::PH_STO_A:
						enter_phase(i2cm_pkg::PH_STO_B, 2,
							i2cm_pkg::L_OE | i2cm_pkg::L_SCL | i2cm_pkg::L_SDA);
					i2cm_pkg::PH_STO_B: begin
						ph  = i2cm_pkg::PH_IDLE;
						fin = 1'b1;
					end
					i2cm_pkg::PH_W_LOW:
						enter_phase(i2cm_pkg::PH_W_HIGH, 1, lines | i2cm_pkg::L_SCL);
					i2cm_pkg::PH_W_HIGH:
						enter_phase(i2cm_pkg::PH_W_TAIL, 1, lines & ~i2cm_pkg::L_SCL);
					i2cm_pkg::PH_W_TAIL: begin
						if (bit_idx < 4'd7) begin
							bit_idx = bit_idx + 4'd1;
							shreg   = {shreg[6:0], 1'b0};
							enter_phase(i2cm_pkg::PH_W_LOW, 1,
								i2cm_pkg::L_OE | (shreg[7] ? i2cm_pkg::L_SDA : 3'b000));
						end else
							enter_phase(i2cm_pkg::PH_A_REL, 1, i2cm_pkg::L_SDA);
					end
					i2cm_pkg::PH_A_REL: begin
						enter_phase(i2cm_pkg::PH_A_POLL, 1, i2cm_pkg::L_SDA | i2cm_pkg::L_SCL);
						ack_wait = 8'd0;
					end
					i2cm_pkg::PH_R_LOW:
						enter_phase(i2cm_pkg::PH_R_HIGH, 1, i2cm_pkg::L_SDA | i2cm_pkg::L_SCL);
					i2cm_pkg::PH_R_HIGH: begin
						// Take the data bit on the last tick of the high unit
						shreg = {shreg[6:0], sda};
						if (bit_idx < 4'd7) begin
							bit_idx = bit_idx + 4'd1;
							enter_phase(i2cm_pkg::PH_R_LOW, 1, i2cm_pkg::L_SDA);
						end else begin
							rx_last = shreg;
							enter_phase(i2cm_pkg::PH_K_LOW, 1,
								i2cm_pkg::L_OE | (ack_sel ? 3'b000 : i2cm_pkg::L_SDA));
						end
					end
					i2cm_pkg::PH_K_LOW:
						enter_phase(i2cm_pkg::PH_K_HIGH, 1, lines | i2cm_pkg::L_SCL);
					i2cm_pkg::PH_K_HIGH: begin
						lines = lines & ~i2cm_pkg::L_SCL;
						ph    = i2cm_pkg::PH_IDLE;
						fin   = 1'b1;
					end
					default: ph = i2cm_pkg::PH_IDLE;
				endcase
			end
		end
		return fin;
	endfunction

	// Work out the result word for one accepted input word
	function automatic i2cm_pkg::result_t predict_word(input i2cm_pkg::item_t w);
		i2cm_pkg::result_t r;
		logic              fin;
		fin = 1'b0;
		if (w.action == i2cm_pkg::ACT_CMD) begin
			// A command while busy is dropped without trace
			if (ph == i2cm_pkg::PH_IDLE) begin
				bit_idx = 4'd0;
				case (w.command)
					i2cm_pkg::CMD_START:
						enter_phase(i2cm_pkg::PH_STA_A, 2,
							i2cm_pkg::L_OE | i2cm_pkg::L_SCL | i2cm_pkg::L_SDA);
					i2cm_pkg::CMD_STOP:
						enter_phase(i2cm_pkg::PH_STO_A, 2, i2cm_pkg::L_OE);
					i2cm_pkg::CMD_WRITE: begin
						shreg = w.tx_byte;
						enter_phase(i2cm_pkg::PH_W_LOW, 1,
							i2cm_pkg::L_OE | (shreg[7] ? i2cm_pkg::L_SDA : 3'b000));
					end
					default: begin
						shreg   = 8'd0;
						ack_sel = w.ack_after_read;
						enter_phase(i2cm_pkg::PH_R_LOW, 1, i2cm_pkg::L_SDA);
					end
				endcase
			end
		end else
			fin = advance_tick(w.sda_sample);
		r.scl_level     = (lines & i2cm_pkg::L_SCL) != 3'b000;
		r.sda_level     = (lines & i2cm_pkg::L_SDA) != 3'b000;
		r.sda_is_output = (lines & i2cm_pkg::L_OE) != 3'b000;
		r.busy_res      = (ph != i2cm_pkg::PH_IDLE);
		r.done_res      = fin;
		r.rx_byte       = rx_last;
		r.nack_error    = nack;
		r.error_count   = timeouts;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver, monitor and receiver stall
	// ------------------------------------------------------------------

	// Send words in bursts of random length with random gaps in between; hold the
	// word steady until it has been taken.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || word_taken)) begin
			word_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				item       <= pending_words.pop_front();
				item_valid <= 1'b1;
				if (burst_left != 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else
				item_valid <= 1'b0;
		end
	end

	// Stall the result side on a pattern that is re-chosen at random intervals:
	// none at all, sparse random, heavy random, or a fixed rhythm.
	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_hold = $urandom_range(16, 96);
		end else
			stall_hold--;
		stall_beat++;
		case (stall_mode)
			0:       result_stall <= 1'b0;
			1:       result_stall <= ($urandom_range(0, 3) == 0);
			2:       result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (stall_beat % 3 == 0);
		endcase
	end

	// Predict on every accepted word, track register writes, and check every
	// accepted result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == i2cm_pkg::REG_ACK_TIMEOUT)
					ack_limit = cfg_data;
				else
					phase_unit = cfg_data;
			end
			if (item_valid && !item_stall) begin
				expected_results.push_back(predict_word(item));
				word_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %h", $time,
						result);
					fail_count++;
				end else begin
					forecast = expected_results.pop_front();
					check_field("scl_level", 16'(forecast.scl_level),
						16'(result.scl_level));
					check_field("sda_level", 16'(forecast.sda_level),
						16'(result.sda_level));
					check_field("sda_is_output", 16'(forecast.sda_is_output),
						16'(result.sda_is_output));
					check_field("busy_res", 16'(forecast.busy_res), 16'(result.busy_res));
					check_field("done_res", 16'(forecast.done_res), 16'(result.done_res));
					check_field("rx_byte", 16'(forecast.rx_byte), 16'(result.rx_byte));
					check_field("nack_error", 16'(forecast.nack_error),
						16'(result.nack_error));
					check_field("error_count", forecast.error_count, result.error_count);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------

	task automatic push_word(input i2cm_pkg::item_t w);
		pending_words.push_back(w);
		planned_words++;
	endtask

	// A tick carries junk in the command fields, which the engine must ignore
	task automatic push_tick(input logic sda);
		i2cm_pkg::item_t w;
		w.action         = i2cm_pkg::ACT_TICK;
		w.command        = 2'($urandom_range(0, 3));
		w.tx_byte        = 8'($urandom);
		w.ack_after_read = 1'($urandom);
		w.sda_sample     = sda;
		push_word(w);
	endtask

	task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] txb, input logic ackr);
		i2cm_pkg::item_t w;
		w.action         = i2cm_pkg::ACT_CMD;
		w.command        = cmd;
		w.tx_byte        = txb;
		w.ack_after_read = ackr;
		w.sda_sample     = 1'($urandom);
		push_word(w);
	endtask

	// Ticks during which the engine is known to be busy, so the odd stray
	// command can be slipped in to check that it is dropped.
	task automatic push_busy_ticks(input int n);
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				push_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
			push_tick(1'($urandom));
		end
	endtask

	// One bus transaction: start, one to max_bytes bytes written or read, stop. Now and then
	// drop the start or the stop, or throw in raw noise and then flush the engine.
	task automatic plan_transaction(input int unit, input int at, input int max_bytes);
		int         nbytes;
		int         highs;
		logic [7:0] data;
		nbytes = $urandom_range(1, max_bytes);
		if ($urandom_range(0, 7) != 0) begin
			push_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom));
			push_busy_ticks(4 * unit);
		end
		repeat (nbytes) begin
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 3))
					0:       data = 8'h00;
					1:       data = 8'hff;
					default: data = 8'($urandom);
				endcase
				push_cmd(i2cm_pkg::CMD_WRITE, data, 1'($urandom));
				// Eight bits of three units each, then the release unit
				push_busy_ticks(25 * unit);
				if ((at <= 64) ? ($urandom_range(0, 3) == 0) : !wide_timeout_done) begin
					// Hold SDA high past the limit; the engine then runs a stop
					wide_timeout_done = (at > 64);
					repeat (at + 1) push_tick(1'b1);
					push_busy_ticks(4 * unit);
				end else begin
					highs = $urandom_range(0, (at < 6) ? at : 6);
					repeat (highs) push_tick(1'b1);
					push_tick(1'b0);
				end
			end else begin
				push_cmd(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom));
				push_busy_ticks(18 * unit);
			end
		end
		if ($urandom_range(0, 7) != 0) begin
			push_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom));
			push_busy_ticks(4 * unit);
		end
		// Ticks while idle change nothing
		repeat ($urandom_range(0, 2)) push_tick(1'($urandom));
		if (unit <= 2 && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 1) == 1)
					push_tick(1'($urandom));
				else
					push_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
			end
			// Low SDA ends any poll at once; this many ticks outlasts any command
			repeat (26 * unit) push_tick(1'b0);
		end
	endtask

	// Wait until every word is taken and every result has come, then let the
	// pipeline settle before touching the registers.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// A ticks-per-phase value of zero runs as one unit per phase
		automatic int at_plan[6]  = '{3, 0, 80, 1, 12, 0};
		automatic int tpp_plan[6] = '{1, 2, 1, 0, 3, 1};
		automatic int unit;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle ticks, start with a stray command, stop, at reset settings
		push_tick(1'b0);
		push_tick(1'b1);
		push_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0);
		push_tick(1'b1);
		push_cmd(i2cm_pkg::CMD_WRITE, 8'hff, 1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b0);
		push_cmd(i2cm_pkg::CMD_STOP, 8'hff, 1'b1);
		push_busy_ticks(4);
		plan_transaction(1, int'(i2cm_pkg::ACK_TIMEOUT_RST), 2);
		wait_drained();

		// Random phases, one register setting each; extremes included
		foreach (at_plan[i]) begin
			write_reg(i2cm_pkg::REG_ACK_TIMEOUT, 8'(at_plan[i]));
			write_reg(i2cm_pkg::REG_TICKS_PER_PHASE, 8'(tpp_plan[i]));
			@(negedge clk);
			cfg_valid <= 1'b0;
			unit          = (tpp_plan[i] == 0) ? 1 : tpp_plan[i];
			planned_words = 0;
			while (planned_words < 30)
				plan_transaction(unit, at_plan[i], 2);
			wait_drained();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: drop out well beyond the slowest legal run
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
